/* rtl/core/wts_pkg.sv */
// ----------------------------------------------------------------------------
// wts_pkg
// Shared types, widths and helpers for the world-to-screen projection block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wts_pkg;

  localparam int NUM_REGS = 8;
  localparam int IDX_W    = 4;
  localparam int REG_W    = 64;
  localparam int LANE_W   = 16;
  localparam int CW       = 32;              // coordinate width
  localparam int MW       = 34;              // combined matrix entry width
  localparam int HW       = 52;              // homogeneous sum width
  localparam int RW       = HW + 1;          // divider remainder width
  localparam int QW       = 33;              // divider quotient width
  localparam int DIV_LAT  = QW + 1;
  localparam int XF_LAT   = 5;
  localparam int TOT_LAT  = XF_LAT + DIV_LAT + 1;

  localparam logic [IDX_W-1:0] REG_VIEW_ROW0 = 4'd0;
  localparam logic [IDX_W-1:0] REG_PROJ_ROW0 = 4'd4;

  localparam logic [CW-1:0] POS_LIM = 32'h7FFF_FFFF;
  localparam logic [CW-1:0] NEG_LIM = 32'h8000_0000;

  typedef logic [3:0][3:0][MW-1:0] mat_t;

  typedef struct packed {
    logic          valid;
    logic          neg;
    logic          pre;
    logic [QW-1:0] q;
  } div_res_t;

  typedef struct packed {
    logic          sat;
    logic [CW-1:0] val;
  } fin_t;

  function automatic logic signed [LANE_W-1:0] lane(input logic [REG_W-1:0] r,
                                                   input int c);
    return signed'(r[c*LANE_W +: LANE_W]);
  endfunction

  function automatic fin_t div_fin(input div_res_t d);
    fin_t          f;
    logic [QW-1:0] lim;
    logic [CW-1:0] mag;
    lim   = d.neg ? QW'(NEG_LIM) : QW'(POS_LIM);
    f.sat = d.pre || (d.q > lim);
    mag   = f.sat ? lim[CW-1:0] : d.q[CW-1:0];
    f.val = d.neg ? (CW'(0) - mag) : mag;
    return f;
  endfunction

endpackage

/* rtl/core/wts_mat.sv */
// ----------------------------------------------------------------------------
// wts_mat
// Configuration registers and the registered view*projection matrix product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wts_mat import wts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  output mat_t             m_o
);

  logic [REG_W-1:0] regs_r [NUM_REGS];
  logic signed [2*LANE_W-1:0] prod_r [4][4][4];
  mat_t m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= '0;
    end else if (cfg_valid && cfg_index < IDX_W'(NUM_REGS)) begin
      regs_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        for (int k = 0; k < 4; k++)
          prod_r[i][j][k] <= lane(regs_r[i], k) *
                             lane(regs_r[int'(REG_PROJ_ROW0) + k], j);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        m_r[i][j] <= MW'(prod_r[i][j][0]) + MW'(prod_r[i][j][1]) +
                     MW'(prod_r[i][j][2]) + MW'(prod_r[i][j][3]);
  end

  assign m_o = m_r;

endmodule

/* rtl/core/wts_xform.sv */
// ----------------------------------------------------------------------------
// wts_xform
// Point times combined matrix: products, partial sums, homogeneous result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wts_xform import wts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] in_x,
  input  logic signed [CW-1:0] in_y,
  input  logic signed [CW-1:0] in_z,
  input  mat_t                 m_i,
  output logic                 h_valid,
  output logic signed [HW-1:0] h_o [4]
);

  logic [XF_LAT-1:0] v_r;
  logic signed [CW-1:0] p1_r [3];
  logic signed [CW-1:0] p2_r [3];
  logic signed [CW+17:0] ph_r [4][3];
  logic signed [CW+16:0] pl_r [4][3];
  logic signed [HW-1:0] sh_r [4];
  logic signed [HW-1:0] sl_r [4];
  logic signed [HW-1:0] h_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= {v_r[XF_LAT-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    p1_r[0] <= in_x;
    p1_r[1] <= in_y;
    p1_r[2] <= in_z;
    p2_r    <= p1_r;
    for (int j = 0; j < 4; j++)
      for (int i = 0; i < 3; i++) begin
        ph_r[j][i] <= p2_r[i] * signed'(m_i[i][j][MW-1:16]);
        pl_r[j][i] <= p2_r[i] * signed'({1'b0, m_i[i][j][15:0]});
      end
    for (int j = 0; j < 4; j++) begin
      sh_r[j] <= HW'(signed'(m_i[3][j])) + HW'(ph_r[j][0]) + HW'(ph_r[j][1]) +
                 HW'(ph_r[j][2]);
      sl_r[j] <= HW'(pl_r[j][0] >>> 16) + HW'(pl_r[j][1] >>> 16) +
                 HW'(pl_r[j][2] >>> 16);
      h_r[j]  <= sh_r[j] + sl_r[j];
    end
  end

  assign h_valid = v_r[XF_LAT-1];
  assign h_o     = h_r;

endmodule

/* rtl/core/wts_div.sv */
// ----------------------------------------------------------------------------
// wts_div
// Pipelined restoring divider, one quotient bit per stage after the first, Q16.16 result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wts_div import wts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  input  logic signed [HW-1:0] n_i,
  input  logic signed [HW-1:0] d_i,
  output div_res_t             res_o
);

  logic [DIV_LAT-1:0] v_r;
  logic [HW-1:0] un_r [DIV_LAT];
  logic [HW-1:0] ud_r [DIV_LAT];
  logic [RW-1:0] r_r  [DIV_LAT];
  logic [QW-1:0] q_r  [DIV_LAT];
  logic          neg_r [DIV_LAT];
  logic          pre_r [DIV_LAT];
  logic [HW-1:0] un0, ud0;
  logic [RW-1:0] t    [DIV_LAT];
  logic          qb   [DIV_LAT];

  assign un0 = n_i[HW-1] ? (HW'(0) - n_i) : n_i;
  assign ud0 = d_i[HW-1] ? (HW'(0) - d_i) : d_i;

  always_comb begin
    t[0]  = '0;
    qb[0] = 1'b0;
    for (int k = 1; k < DIV_LAT; k++) begin
      if (k <= 17) t[k] = {r_r[k-1][RW-2:0], un_r[k-1][33-k-16]};
      else         t[k] = {r_r[k-1][RW-2:0], 1'b0};
      qb[k] = (t[k] >= {1'b0, ud_r[k-1]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= {v_r[DIV_LAT-2:0], valid_i};
  end

  always_ff @(posedge clk) begin
    un_r[0]  <= un0;
    ud_r[0]  <= ud0;
    r_r[0]   <= RW'(un0 >> 17);
    q_r[0]   <= '0;
    neg_r[0] <= n_i[HW-1] ^ d_i[HW-1];
    pre_r[0] <= ({17'd0, un0} >= {ud0, 17'd0});
    for (int k = 1; k < DIV_LAT; k++) begin
      un_r[k]  <= un_r[k-1];
      ud_r[k]  <= ud_r[k-1];
      r_r[k]   <= qb[k] ? (t[k] - {1'b0, ud_r[k-1]}) : t[k];
      q_r[k]   <= {q_r[k-1][QW-2:0], qb[k]};
      neg_r[k] <= neg_r[k-1];
      pre_r[k] <= pre_r[k-1];
    end
  end

  assign res_o.valid = v_r[DIV_LAT-1];
  assign res_o.neg   = neg_r[DIV_LAT-1];
  assign res_o.pre   = pre_r[DIV_LAT-1];
  assign res_o.q     = q_r[DIV_LAT-1];

endmodule

/* rtl/core/world_to_screen_project_top.sv */
// ----------------------------------------------------------------------------
// world_to_screen_project_top
// View*projection transform of a Q16.16 point with perspective divide.
// ----------------------------------------------------------------------------
// channel | handshake              | payload
// in      | start / busy           | in_world_x, in_world_y, in_world_z
// out     | out_valid (strobe)     | out_screen_x/y/z, out_w_zero, out_saturated
// cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One point per cycle; busy stays low. A point passes 5 transform stages,
// 34 divider stages (one quotient bit each after the first), one output register.
// A cfg write reaches the matrix via config, product and sum registers.
// Synchronous active-low reset clears valids and config registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module world_to_screen_project_top import wts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] in_world_x,
  input  logic signed [CW-1:0] in_world_y,
  input  logic signed [CW-1:0] in_world_z,
  output logic                 out_valid,
  output logic signed [CW-1:0] out_screen_x,
  output logic signed [CW-1:0] out_screen_y,
  output logic signed [CW-1:0] out_screen_z,
  output logic                 out_w_zero,
  output logic                 out_saturated,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  mat_t                 m;
  logic                 h_valid;
  logic signed [HW-1:0] h [4];
  div_res_t             dx, dy, dz;
  fin_t                 fx, fy, fz;
  logic                 wz_d   [DIV_LAT];
  logic                 zneg_d [DIV_LAT];
  logic                 zsat_d [DIV_LAT];
  logic [CW-1:0]        zraw_d [DIV_LAT];
  logic                 zsat0;
  logic [CW-1:0]        zraw0;
  logic                 valid_r;
  logic [CW-1:0]        sx_r, sy_r, sz_r;
  logic                 wz_r, sat_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  wts_mat u_mat (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data, .m_o(m)
  );

  wts_xform u_xform (
    .clk, .rst_n, .in_valid(start), .in_x(in_world_x), .in_y(in_world_y),
    .in_z(in_world_z), .m_i(m), .h_valid, .h_o(h)
  );

  wts_div u_div_x (.clk, .rst_n, .valid_i(h_valid), .n_i(h[0]), .d_i(h[3]), .res_o(dx));
  wts_div u_div_y (.clk, .rst_n, .valid_i(h_valid), .n_i(h[1]), .d_i(h[3]), .res_o(dy));
  wts_div u_div_z (.clk, .rst_n, .valid_i(h_valid), .n_i(h[2]), .d_i(h[3]), .res_o(dz));

  always_comb begin
    zsat0 = 1'b0;
    zraw0 = h[2][CW-1:0];
    if (h[2] > HW'(signed'(POS_LIM))) begin
      zsat0 = 1'b1;
      zraw0 = POS_LIM;
    end else if (h[2] < HW'(signed'(NEG_LIM))) begin
      zsat0 = 1'b1;
      zraw0 = NEG_LIM;
    end
  end

  always_ff @(posedge clk) begin
    wz_d[0]   <= (h[3] == '0);
    zneg_d[0] <= h[2][HW-1];
    zsat_d[0] <= zsat0;
    zraw_d[0] <= zraw0;
    for (int k = 1; k < DIV_LAT; k++) begin
      wz_d[k]   <= wz_d[k-1];
      zneg_d[k] <= zneg_d[k-1];
      zsat_d[k] <= zsat_d[k-1];
      zraw_d[k] <= zraw_d[k-1];
    end
  end

  assign fx = div_fin(dx);
  assign fy = div_fin(dy);
  assign fz = div_fin(dz);

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= dx.valid;
  end

  always_ff @(posedge clk) begin
    if (wz_d[DIV_LAT-1]) begin
      sx_r  <= '0;
      sy_r  <= '0;
      sz_r  <= '0;
      wz_r  <= 1'b1;
      sat_r <= 1'b0;
    end else begin
      sx_r  <= fx.val;
      sy_r  <= fy.val;
      sz_r  <= zneg_d[DIV_LAT-1] ? zraw_d[DIV_LAT-1] : fz.val;
      wz_r  <= 1'b0;
      sat_r <= fx.sat | fy.sat |
               (zneg_d[DIV_LAT-1] ? zsat_d[DIV_LAT-1] : fz.sat);
    end
  end

  assign out_valid     = valid_r;
  assign out_screen_x  = sx_r;
  assign out_screen_y  = sy_r;
  assign out_screen_z  = sz_r;
  assign out_w_zero    = wz_r;
  assign out_saturated = sat_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##TOT_LAT out_valid)
    else $error("transaction lost in pipeline");

  a_wzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_w_zero) |-> (out_screen_x == 0 && out_screen_y == 0 &&
                                   out_screen_z == 0 && !out_saturated))
    else $error("zero w result not cleared");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_screen_x == POS_LIM || out_screen_x == NEG_LIM ||
       out_screen_y == POS_LIM || out_screen_y == NEG_LIM ||
       out_screen_z == POS_LIM || out_screen_z == NEG_LIM))
    else $error("saturated flag without clamped coordinate");
`endif

endmodule

/* dv/world_to_screen_project_top_tb.sv */
// ----------------------------------------------------------------------------
// world_to_screen_project_top_tb
// Self-checking bench for the world-to-screen projection block. It loads sets
// of view and projection rows, streams points via start/busy and checks every
// strobed result against a table entry or a bit-accurate transform-and-divide
// predictor. A table of directed points comes first, then random phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module world_to_screen_project_top_tb;
  import wts_pkg::*;

  localparam string PASS_MSG   = "world_to_screen_project_top test passed";
  localparam int    LIMIT      = 400000;
  localparam int    PHASES     = 10;
  localparam int    PER_PHASE  = 113;

  typedef enum int {
    CFG_ZERO, CFG_IDENT, CFG_WSMALL, CFG_MAXPOS, CFG_MAXNEG,
    CFG_RAND_FULL, CFG_RAND_SMALL, CFG_PERSP
  } cfg_set_e;

  typedef struct {
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] sz;
    logic          wz;
    logic          sat;
  } screen_t;

  typedef struct {
    cfg_set_e      set;
    logic [CW-1:0] x, y, z;
    bit            typed;
    screen_t       res;
  } point_row_t;

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 start = 0;
  logic                 busy;
  logic signed [CW-1:0] in_world_x = '0, in_world_y = '0, in_world_z = '0;
  logic                 out_valid;
  logic signed [CW-1:0] out_screen_x, out_screen_y, out_screen_z;
  logic                 out_w_zero, out_saturated;
  logic                 cfg_valid = 0;
  logic                 cfg_ready;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [REG_W-1:0]     cfg_data = '0;

  logic [REG_W-1:0] mat_rows [NUM_REGS];
  screen_t          pending_screens [$];
  int               errors = 0;
  int               cycles = 0;
  bit               allow_idle = 1;

  world_to_screen_project_top i_dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("world_to_screen_project_top test failed");
      $finish;
    end
  end

  function automatic longint lane_of(logic [REG_W-1:0] r, int c);
    logic signed [LANE_W-1:0] v;
    v = r[c*LANE_W +: LANE_W];
    return longint'(v);
  endfunction

  function automatic longint floor_q16(longint v);
    return v >>> 16;
  endfunction

  function automatic logic [CW-1:0] div_q16(longint n, longint d, inout logic sat);
    bit                neg;
    longint unsigned   un, ud, q, r, f, mag, lim;
    neg = (n < 0) != (d < 0);
    un  = (n < 0) ? -n : n;
    ud  = (d < 0) ? -d : d;
    q   = un / ud;
    r   = un % ud;
    f   = 0;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (q >= 65536) begin
      sat = 1;
      return neg ? NEG_LIM : POS_LIM;
    end
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      f = f << 1;
      if (r >= ud) begin
        r = r - ud;
        f = f | 1;
      end
    end
    mag = (q << 16) | f;
    if (mag > lim) begin
      sat = 1;
      mag = lim;
    end
    return neg ? CW'(-mag) : CW'(mag);
  endfunction

  function automatic screen_t project_point(logic [CW-1:0] x, y, z);
    longint  m [4][4];
    longint  p [3];
    longint  h [4];
    longint  s, hi, lo;
    screen_t o;
    logic    sat;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        s = 0;
        for (int k = 0; k < 4; k++)
          s += lane_of(mat_rows[i], k) * lane_of(mat_rows[4 + k], j);
        m[i][j] = s;
      end
    p[0] = longint'($signed(x));
    p[1] = longint'($signed(y));
    p[2] = longint'($signed(z));
    for (int j = 0; j < 4; j++) begin
      s = m[3][j];
      for (int i = 0; i < 3; i++) begin
        hi = floor_q16(m[i][j]);
        lo = m[i][j] - hi * 65536;
        s += p[i] * hi + floor_q16(p[i] * lo);
      end
      h[j] = s;
    end
    sat = 0;
    if (h[3] == 0) begin
      o = '{sx: '0, sy: '0, sz: '0, wz: 1, sat: 0};
      return o;
    end
    o.sx = div_q16(h[0], h[3], sat);
    o.sy = div_q16(h[1], h[3], sat);
    if (h[2] >= 0) o.sz = div_q16(h[2], h[3], sat);
    else if (h[2] < -64'sd2147483648) begin
      sat  = 1;
      o.sz = NEG_LIM;
    end else o.sz = h[2][CW-1:0];
    o.wz  = 0;
    o.sat = sat;
    return o;
  endfunction

  function automatic logic [REG_W-1:0] pack_lanes(int l0, l1, l2, l3);
    return {16'(l3), 16'(l2), 16'(l1), 16'(l0)};
  endfunction

  function automatic int small_lane();
    return int'($urandom_range(0, 1024)) - 512;
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_REGS) mat_rows[idx] = val;
  endtask

  task automatic drain();
    start <= 0;
    do @(posedge clk); while (pending_screens.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_matrices(cfg_set_e set);
    logic [REG_W-1:0] v [NUM_REGS];
    for (int i = 0; i < NUM_REGS; i++) begin
      case (set)
        CFG_ZERO:       v[i] = '0;
        CFG_MAXPOS:     v[i] = {4{16'h7FFF}};
        CFG_MAXNEG:     v[i] = {4{16'h8000}};
        CFG_RAND_FULL:  v[i] = {$urandom, $urandom};
        CFG_RAND_SMALL: v[i] = pack_lanes(small_lane(), small_lane(),
                                          small_lane(), small_lane());
        default:        v[i] = pack_lanes(i % 4 == 0 ? 256 : 0, i % 4 == 1 ? 256 : 0,
                                          i % 4 == 2 ? 256 : 0, i % 4 == 3 ? 256 : 0);
      endcase
    end
    if (set == CFG_WSMALL) v[REG_PROJ_ROW0 + 3] = pack_lanes(0, 0, 0, 1);
    if (set == CFG_PERSP) begin
      v[REG_VIEW_ROW0 + 3] = pack_lanes(small_lane(), small_lane(), small_lane(), 0);
      v[REG_PROJ_ROW0 + 0] = pack_lanes(small_lane(), 0, 0, 0);
      v[REG_PROJ_ROW0 + 1] = pack_lanes(0, small_lane(), 0, 0);
      v[REG_PROJ_ROW0 + 2] = pack_lanes(0, 0, small_lane(), 256);
      v[REG_PROJ_ROW0 + 3] = pack_lanes(0, 0, small_lane(), 0);
    end
    for (int i = 0; i < NUM_REGS; i++) write_reg(IDX_W'(i), v[i]);
    write_reg(IDX_W'($urandom_range(NUM_REGS, 15)), {$urandom, $urandom});
    cfg_valid <= 0;
    repeat (4) @(posedge clk);
  endtask

  task automatic send_point(logic [CW-1:0] x, y, z, bit typed, screen_t res);
    start      <= 1;
    in_world_x <= x;
    in_world_y <= y;
    in_world_z <= z;
    do @(posedge clk); while (busy);
    pending_screens.push_back(typed ? res : project_point(x, y, z));
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic logic [CW-1:0] rand_coord(int mode);
    case (mode)
      0:       return $urandom;
      1:       return CW'(int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      2:       return '0;
      default: return $urandom_range(0, 1) ? POS_LIM : NEG_LIM;
    endcase
  endfunction

  always @(posedge clk) begin
    screen_t e;
    if (rst_n && out_valid) begin
      if (pending_screens.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h", $time,
                 out_screen_x, out_screen_y, out_screen_z);
        errors++;
      end else begin
        e = pending_screens.pop_front();
        if (out_screen_x !== e.sx) begin
          $display("%0t: screen_x exp %h got %h", $time, e.sx, out_screen_x); errors++;
        end
        if (out_screen_y !== e.sy) begin
          $display("%0t: screen_y exp %h got %h", $time, e.sy, out_screen_y); errors++;
        end
        if (out_screen_z !== e.sz) begin
          $display("%0t: screen_z exp %h got %h", $time, e.sz, out_screen_z); errors++;
        end
        if (out_w_zero !== e.wz) begin
          $display("%0t: w_zero exp %b got %b", $time, e.wz, out_w_zero); errors++;
        end
        if (out_saturated !== e.sat) begin
          $display("%0t: saturated exp %b got %b", $time, e.sat, out_saturated); errors++;
        end
      end
    end
  end

  initial begin
    point_row_t rows [$];
    screen_t    zero_w, none;
    cfg_set_e   cur, set;
    int         mode;
    zero_w = '{sx: '0, sy: '0, sz: '0, wz: 1, sat: 0};
    none   = zero_w;
    for (int i = 0; i < NUM_REGS; i++) mat_rows[i] = '0;

    // reset config: w is always zero
    rows.push_back('{CFG_ZERO, 32'h0, 32'h0, 32'h0, 1, zero_w});
    rows.push_back('{CFG_ZERO, POS_LIM, POS_LIM, POS_LIM, 1, zero_w});
    rows.push_back('{CFG_ZERO, NEG_LIM, NEG_LIM, NEG_LIM, 1, zero_w});
    // identity: point passes through, negative z takes the raw path
    rows.push_back('{CFG_IDENT, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 1,
                     '{32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 0, 0}});
    rows.push_back('{CFG_IDENT, POS_LIM, NEG_LIM, NEG_LIM, 1,
                     '{POS_LIM, NEG_LIM, NEG_LIM, 0, 0}});
    rows.push_back('{CFG_IDENT, 32'h0000_0001, 32'h0, 32'h0, 1,
                     '{32'h0000_0001, 32'h0, 32'h0, 0, 0}});
    rows.push_back('{CFG_IDENT, 32'h1234_5678, 32'hFEDC_BA98, 32'h8765_4321, 0, none});
    // tiny w: large quotients clamp
    rows.push_back('{CFG_WSMALL, POS_LIM, NEG_LIM, POS_LIM, 1,
                     '{POS_LIM, NEG_LIM, POS_LIM, 0, 1}});
    rows.push_back('{CFG_WSMALL, 32'h0000_0100, 32'hFFFF_FF00, NEG_LIM, 0, none});
    rows.push_back('{CFG_WSMALL, 32'h0, 32'h0, 32'h0, 0, none});
    rows.push_back('{CFG_MAXPOS, POS_LIM, POS_LIM, POS_LIM, 0, none});
    rows.push_back('{CFG_MAXPOS, NEG_LIM, 32'h0, POS_LIM, 0, none});
    rows.push_back('{CFG_MAXNEG, NEG_LIM, NEG_LIM, NEG_LIM, 0, none});
    rows.push_back('{CFG_MAXNEG, 32'h0001_0000, NEG_LIM, 32'h0, 0, none});
    rows.push_back('{CFG_PERSP, 32'h0003_0000, 32'hFFFE_0000, 32'h0000_0000, 0, none});
    rows.push_back('{CFG_PERSP, 32'h0003_0000, 32'hFFFE_0000, 32'h0005_0000, 0, none});
    rows.push_back('{CFG_PERSP, 32'h0003_0000, 32'hFFFE_0000, 32'hFFFB_0000, 0, none});

    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    cur = CFG_ZERO;
    foreach (rows[i]) begin
      if (rows[i].set != cur) begin
        drain();
        cur = rows[i].set;
        load_matrices(cur);
      end
      send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].res);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      allow_idle = (ph < PHASES - 2);
      case (ph % 5)
        0: set = CFG_PERSP;
        1: set = CFG_RAND_SMALL;
        2: set = CFG_RAND_FULL;
        3: set = (ph < 5) ? CFG_IDENT : CFG_ZERO;
        default: set = (ph < 5) ? CFG_WSMALL : CFG_MAXNEG;
      endcase
      load_matrices(set);
      for (int n = 0; n < PER_PHASE; n++) begin
        if (ph == 3 && n == 50) drain();
        mode = $urandom_range(0, 9) < 4 ? 0 : ($urandom_range(0, 9) < 8 ? 1 : 2 + $urandom_range(0, 1));
        send_point(rand_coord(mode), rand_coord(mode),
                   $urandom_range(0, 7) == 0 ? 32'h0 : rand_coord(mode), 0, none);
      end
    end

    start <= 0;
    while (pending_screens.size() != 0) @(posedge clk);
    repeat (TOT_LAT + 10) @(posedge clk);
    if (errors == 0) $display(PASS_MSG);
    else $display("world_to_screen_project_top test failed");
    $finish;
  end

endmodule
